@@ sv/kvt_pkg.sv @@
`default_nettype none

package kvt_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int OP_W         = 3;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;
    localparam int PICK_W       = 32;
    localparam int CNT_OUT_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_INSERT = 3'd1,
        OP_FIND   = 3'd2,
        OP_UPDATE = 3'd3,
        OP_DELETE = 3'd4,
        OP_UPSERT = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT,
        ST_FETCH,
        ST_MOVE,
        ST_MOD,
        ST_REPL,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ sv/kvt_ram.sv @@
`default_nettype none

module kvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/key_value_table_random_replace.sv @@
`default_nettype none

// Key/value table, up to CAPACITY unique 32-bit keys with 32-bit values.
// Input channel (in_valid/in_ready) carries op, lookup_key, new_value and
// random_pick; output channel (out_valid/out_ready) returns ok, read_value
// and entry_count, exactly one result transaction per input transaction.
// Entries sit packed in slots 0..count-1 of two RAMs (keys, values), each
// with one write and one read port; a single key comparator scans them
// one slot per cycle. A scan that misses reads all count slots; a hit in
// slot i stops the scan early. Find then adds a value fetch and delete a
// move of the last entry. Clear and unused codes skip the scan. An upsert
// into a full table adds three multiplier passes for random_pick mod
// CAPACITY, then the overwrite. The result becomes valid in the same cycle
// that in_ready rises again. One item at a time: in_ready is high only
// when the sequencer is idle. The result sits in an output register, so a
// new item is taken while a result waits; a stalled receiver holds the
// sequencer only when the next result is ready and the register is still
// full.
// Reset empties the table (count 0); RAM contents are not cleared.
module key_value_table_random_replace
    import kvt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [OP_W-1:0]      op,
    input  wire logic [KEY_W-1:0]     lookup_key,
    input  wire logic [VAL_W-1:0]     new_value,
    input  wire logic [PICK_W-1:0]    random_pick,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      ok,
    output logic      [VAL_W-1:0]     read_value,
    output logic      [CNT_OUT_W-1:0] entry_count
);

    localparam int IDXW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNTW  = $clog2(CAPACITY + 1);
    // reciprocal for random_pick mod CAPACITY: q = (pick * RECIP) >> (32 + LSH)
    localparam int LSH   = $clog2(CAPACITY);
    localparam int MW    = 17;
    localparam int LO_W  = MW - 1;
    localparam int RCPW  = 2 * MW - 1;
    localparam int PRODW = PICK_W + MW;
    localparam int ACCW  = PICK_W + RCPW;
    localparam logic [63:0] RECIP =
        ((64'd1 << (PICK_W + LSH)) + 64'(CAPACITY - 1)) / 64'(CAPACITY);
    localparam logic [MW-1:0] RECIP_LO = {1'b0, RECIP[LO_W-1:0]};
    localparam logic [MW-1:0] RECIP_HI = RECIP[RCPW-1:LO_W];

    state_t              state_reg, state_next;
    logic [CNTW-1:0]     count_reg, count_next;
    logic [CNTW-1:0]     addr_reg, addr_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          phase_reg, phase_next;

    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VAL_W-1:0]    value_reg, value_next;
    logic [PICK_W-1:0]   pick_reg, pick_next;
    logic [IDXW-1:0]     slot_reg, slot_next;
    logic                found_reg, found_next;
    logic                res_ok_reg, res_ok_next;
    logic [VAL_W-1:0]    res_value_reg, res_value_next;
    logic [IDXW-1:0]     rem_reg, rem_next;
    logic [ACCW-1:0]     acc_reg, acc_next;
    logic                out_ok_reg, out_ok_next;
    logic [VAL_W-1:0]    out_value_reg, out_value_next;
    logic [CNT_OUT_W-1:0] out_count_reg, out_count_next;

    logic                key_we, val_we;
    logic [IDXW-1:0]     key_waddr, val_waddr, key_raddr, val_raddr;
    logic [KEY_W-1:0]    key_wdata, key_rdata;
    logic [VAL_W-1:0]    val_wdata, val_rdata;

    logic                full;
    logic [CNTW-1:0]     hit_pos, last_pos;
    logic [CNTW+CNT_OUT_W-1:0] count_ext;
    logic [PICK_W-1:0]   mul_a;
    logic [MW-1:0]       mul_b;
    logic [PRODW-1:0]    mul_p;
    logic [PICK_W-1:0]   quo;

    kvt_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    kvt_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    assign full      = (count_reg == CNTW'(CAPACITY));
    assign hit_pos   = addr_reg - 1'b1;
    assign last_pos  = count_reg - 1'b1;
    assign count_ext = {{CNT_OUT_W{1'b0}}, count_next};
    assign mul_p     = PRODW'(mul_a) * PRODW'(mul_b);
    assign quo       = PICK_W'(acc_reg >> (PICK_W + LSH));

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign ok          = out_ok_reg;
    assign read_value  = out_value_reg;
    assign entry_count = out_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            addr_reg      <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        value_reg     <= value_next;
        pick_reg      <= pick_next;
        slot_reg      <= slot_next;
        found_reg     <= found_next;
        res_ok_reg    <= res_ok_next;
        res_value_reg <= res_value_next;
        rem_reg       <= rem_next;
        acc_reg       <= acc_next;
        out_ok_reg    <= out_ok_next;
        out_value_reg <= out_value_next;
        out_count_reg <= out_count_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        cmp_vld_next   = cmp_vld_reg;
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        pick_next      = pick_reg;
        slot_next      = slot_reg;
        found_next     = found_reg;
        res_ok_next    = res_ok_reg;
        res_value_next = res_value_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        out_ok_next    = out_ok_reg;
        out_value_next = out_value_reg;
        out_count_next = out_count_reg;

        key_we    = 1'b0;
        val_we    = 1'b0;
        key_waddr = slot_reg;
        val_waddr = slot_reg;
        key_wdata = key_reg;
        val_wdata = value_reg;
        key_raddr = addr_reg[IDXW-1:0];
        val_raddr = slot_reg;
        mul_a     = pick_reg;
        mul_b     = RECIP_LO;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next        = op;
                    key_next       = lookup_key;
                    value_next     = new_value;
                    pick_next      = random_pick;
                    addr_next      = '0;
                    cmp_vld_next   = 1'b0;
                    res_ok_next    = 1'b0;
                    res_value_next = '0;
                    case (op_t'(op))
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            res_ok_next = 1'b1;
                            state_next  = ST_DONE;
                        end
                        OP_INSERT, OP_FIND, OP_UPDATE, OP_DELETE, OP_UPSERT:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // one read issued per cycle, compare checks the slot read before the current address
            ST_SCAN:
            begin
                if (cmp_vld_reg && (key_rdata == key_reg))
                begin
                    found_next = 1'b1;
                    slot_next  = hit_pos[IDXW-1:0];
                    state_next = ST_ACT;
                end
                else if (addr_reg == count_reg)
                begin
                    found_next = 1'b0;
                    state_next = ST_ACT;
                end
                else
                begin
                    cmp_vld_next = 1'b1;
                    addr_next    = addr_reg + 1'b1;
                end
            end

            ST_ACT:
            begin
                state_next = ST_DONE;
                case (op_t'(op_reg))
                    OP_INSERT:
                    begin
                        if (!found_reg && !full)
                        begin
                            key_we      = 1'b1;
                            val_we      = 1'b1;
                            key_waddr   = count_reg[IDXW-1:0];
                            val_waddr   = count_reg[IDXW-1:0];
                            count_next  = count_reg + 1'b1;
                            res_ok_next = 1'b1;
                        end
                    end
                    OP_FIND:
                    begin
                        if (found_reg)
                        begin
                            val_raddr   = slot_reg;
                            res_ok_next = 1'b1;
                            state_next  = ST_FETCH;
                        end
                    end
                    OP_UPDATE:
                    begin
                        if (found_reg)
                        begin
                            val_we      = 1'b1;
                            res_ok_next = 1'b1;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (found_reg)
                        begin
                            key_raddr   = last_pos[IDXW-1:0];
                            val_raddr   = last_pos[IDXW-1:0];
                            count_next  = last_pos;
                            res_ok_next = 1'b1;
                            state_next  = ST_MOVE;
                        end
                    end
                    OP_UPSERT:
                    begin
                        res_ok_next = 1'b1;
                        if (found_reg)
                        begin
                            val_we = 1'b1;
                        end
                        else if (!full)
                        begin
                            key_we     = 1'b1;
                            val_we     = 1'b1;
                            key_waddr  = count_reg[IDXW-1:0];
                            val_waddr  = count_reg[IDXW-1:0];
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            phase_next = '0;
                            state_next = ST_MOD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_FETCH:
            begin
                res_value_next = val_rdata;
                state_next     = ST_DONE;
            end

            // last entry fills the freed slot
            ST_MOVE:
            begin
                key_we     = 1'b1;
                val_we     = 1'b1;
                key_wdata  = key_rdata;
                val_wdata  = val_rdata;
                state_next = ST_DONE;
            end

            // pick * RECIP in two halves, then remainder = pick - q * CAPACITY
            ST_MOD:
            begin
                case (phase_reg)
                    2'd0:
                    begin
                        acc_next   = ACCW'(mul_p);
                        phase_next = 2'd1;
                    end
                    2'd1:
                    begin
                        mul_b      = RECIP_HI;
                        acc_next   = acc_reg + (ACCW'(mul_p) << LO_W);
                        phase_next = 2'd2;
                    end
                    default:
                    begin
                        mul_a      = quo;
                        mul_b      = MW'(CAPACITY);
                        rem_next   = pick_reg[IDXW-1:0] - mul_p[IDXW-1:0];
                        state_next = ST_REPL;
                    end
                endcase
            end

            ST_REPL:
            begin
                key_we     = 1'b1;
                val_we     = 1'b1;
                key_waddr  = rem_reg;
                val_waddr  = rem_reg;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_value_next = res_value_reg;
                    out_count_next = count_ext[CNT_OUT_W-1:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
